/* design/spp_pkg.sv */
package spp_pkg;

   // Which field the next packet byte belongs to; the codes double as field kinds.
   typedef enum logic [2:0] {
      PH_ID_HI  = 3'd0,
      PH_ID_LO  = 3'd1,
      PH_LEN_HI = 3'd2,
      PH_LEN_LO = 3'd3,
      PH_TOPIC  = 3'd4,
      PH_QOS    = 3'd5
   } phase_type;

   // Error codes reported with the final byte of a packet.
   typedef enum logic [2:0] {
      ERR_OK        = 3'd0,
      ERR_SHORT_ID  = 3'd1,
      ERR_SHORT_LEN = 3'd2,
      ERR_SHORT_TOP = 3'd3,
      ERR_NO_QOS    = 3'd4
   } err_type;

   // One packet byte as it arrives.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } req_type;

   // One parse result, one per packet byte.
   typedef struct packed {
      logic [2:0]  field_kind;
      logic [15:0] field_value;
      logic [7:0]  topic_number;
      logic        topic_end;
      logic        packet_done;
      logic [2:0]  error_code;
   } rsp_type;

endpackage

/* design/subscribe_payload_parser.sv */
// Channel  Direction  Ports                               Moves
// req      in         req_valid, req_stall, req_payload   one packet byte per transfer
// rsp      out        rsp_valid, rsp_stall, rsp_payload   one parse result per byte
//
// Every byte gives one result; a byte can be taken in every cycle in which req_stall is low.
// A byte passes through the input register, then the result register, from which its result is offered.
// Reset is synchronous and returns the parser to the packet identifier high byte.
// A stall on rsp holds the result register; req stalls only once both registers are full.
module subscribe_payload_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  spp_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output spp_pkg::rsp_type rsp_payload
);

   logic             in_valid_ff;
   spp_pkg::req_type in_data_ff;
   logic             out_valid_ff;
   spp_pkg::rsp_type out_data_ff;
   spp_pkg::rsp_type step_rsp;
   logic             out_hold;
   logic             advance;

   // The result register holds while its transfer is stalled.
   assign out_hold  = out_valid_ff & rsp_stall;
   assign advance   = in_valid_ff & ~out_hold;
   assign req_stall = in_valid_ff & out_hold;

   spp_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .req     (in_data_ff),
      .rsp     (step_rsp)
   );

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_data_ff <= req_payload;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (!out_hold) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= step_rsp;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

endmodule

/* design/spp_core.sv */
module spp_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  spp_pkg::req_type req,
   output spp_pkg::rsp_type rsp
);

   spp_pkg::phase_type phase_ff, phase_in;
   logic [7:0]         held_ff, held_in;
   logic [15:0]        remain_ff, remain_in;
   logic [7:0]         count_ff, count_in;

   logic [15:0]        joined;
   logic [15:0]        remain_dec;
   spp_pkg::err_type   err;

   assign joined     = {held_ff, req.data_byte};
   assign remain_dec = remain_ff - 16'd1;

   // Decode the current byte against the parse phase and form the next state.
   always_comb begin
      phase_in         = phase_ff;
      held_in          = held_ff;
      remain_in        = remain_ff;
      count_in         = count_ff;
      err              = spp_pkg::ERR_OK;
      rsp.field_kind   = 3'(phase_ff);
      rsp.field_value  = {8'd0, req.data_byte};
      rsp.topic_number = count_ff;
      rsp.topic_end    = 1'b0;
      unique case (phase_ff)
         spp_pkg::PH_ID_HI: begin
            held_in  = req.data_byte;
            phase_in = spp_pkg::PH_ID_LO;
            err      = spp_pkg::ERR_SHORT_ID;
         end
         spp_pkg::PH_ID_LO: begin
            rsp.field_value = joined;
            phase_in        = spp_pkg::PH_LEN_HI;
         end
         spp_pkg::PH_LEN_HI: begin
            held_in  = req.data_byte;
            phase_in = spp_pkg::PH_LEN_LO;
            err      = spp_pkg::ERR_SHORT_LEN;
         end
         spp_pkg::PH_LEN_LO: begin
            rsp.field_value = joined;
            remain_in       = joined;
            if (joined == 16'd0) begin
               phase_in = spp_pkg::PH_QOS;
               err      = spp_pkg::ERR_NO_QOS;
            end else begin
               phase_in = spp_pkg::PH_TOPIC;
               err      = spp_pkg::ERR_SHORT_TOP;
            end
         end
         spp_pkg::PH_TOPIC: begin
            remain_in = remain_dec;
            if (remain_dec == 16'd0) begin
               rsp.topic_end = 1'b1;
               phase_in      = spp_pkg::PH_QOS;
               err           = spp_pkg::ERR_NO_QOS;
            end else begin
               err = spp_pkg::ERR_SHORT_TOP;
            end
         end
         default: begin
            // The QoS byte closes an entry; the entry count saturates.
            rsp.field_kind = 3'(spp_pkg::PH_QOS);
            if (count_ff != 8'hFF) begin
               count_in = count_ff + 8'd1;
            end
            phase_in = spp_pkg::PH_LEN_HI;
         end
      endcase
      rsp.packet_done = req.final_byte;
      rsp.error_code  = req.final_byte ? 3'(err) : 3'(spp_pkg::ERR_OK);
   end

   // Parse state advances once per transfer; a final byte restarts the packet.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= spp_pkg::PH_ID_HI;
         held_ff   <= 8'd0;
         remain_ff <= 16'd0;
         count_ff  <= 8'd0;
      end else if (advance) begin
         if (req.final_byte) begin
            phase_ff  <= spp_pkg::PH_ID_HI;
            held_ff   <= 8'd0;
            remain_ff <= 16'd0;
            count_ff  <= 8'd0;
         end else begin
            phase_ff  <= phase_in;
            held_ff   <= held_in;
            remain_ff <= remain_in;
            count_ff  <= count_in;
         end
      end
   end

endmodule
